### rtl/tlbfa_pkg.sv
// Shared types and constants for the fully associative TLB.
`default_nettype none

package tlbfa_pkg;

    localparam int unsigned PAGE_W = 32;
    localparam int unsigned CNT_W  = 32;

    typedef enum logic [1:0] {
        OP_LOOKUP    = 2'd0,
        OP_ADD       = 2'd1,
        OP_INVAL     = 2'd2,
        OP_INVAL_ALL = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [PAGE_W-1:0] vpage;
        logic [PAGE_W-1:0] ppage;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [PAGE_W-1:0] tpage;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  miss_total;
    } t_result;

endpackage

`default_nettype wire

### rtl/tlb_fully_assoc_lru_top.sv
// An accepted word waits in the input register and moves to the result register
// once that is free or draining. Throughput: one word per cycle while results are
// taken; tag compare and LRU update finish in one pass between the two registers.
// Reset (synchronous, active low) empties the buffer, clears both counters and
// drops any word in flight.
// Top level of the fully associative TLB with LRU replacement.
`default_nettype none

module tlb_fully_assoc_lru_top #(
    parameter int unsigned TLB_ENTRIES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_op,
    input  wire  [31:0] i_virtual_page,
    input  wire  [31:0] i_physical_page,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_hit,
    output logic [31:0] o_translated_page,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total
);

    logic               r_in_valid;
    tlbfa_pkg::t_req    r_req;
    logic               advance;
    tlbfa_pkg::t_result res_d, res_q;

    // The staged word moves on whenever the result register is free or draining.
    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req.op    <= tlbfa_pkg::t_op'(i_op);
            r_req.vpage <= i_virtual_page;
            r_req.ppage <= i_physical_page;
        end
    end

    tlbfa_entries #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (r_req),
        .o_res   (res_d)
    );

    tlbfa_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res       (res_d),
        .i_out_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_res       (res_q)
    );

    assign o_hit             = res_q.hit;
    assign o_translated_page = res_q.tpage;
    assign o_hit_total       = res_q.hit_total;
    assign o_miss_total      = res_q.miss_total;

endmodule

`default_nettype wire

### rtl/tlbfa_entries.sv
// Entry array with parallel tag compare, LRU rank update and hit/miss counters.
`default_nettype none

module tlbfa_entries #(
    parameter int unsigned TLB_ENTRIES = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  tlbfa_pkg::t_req     i_req,
    output tlbfa_pkg::t_result  o_res
);

    localparam int unsigned RW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam logic [RW-1:0] OLDEST = RW'(TLB_ENTRIES - 1);

    logic [TLB_ENTRIES-1:0]           r_valid, n_valid;
    logic [tlbfa_pkg::PAGE_W-1:0]     r_vpage [TLB_ENTRIES];
    logic [tlbfa_pkg::PAGE_W-1:0]     n_vpage [TLB_ENTRIES];
    logic [tlbfa_pkg::PAGE_W-1:0]     r_ppage [TLB_ENTRIES];
    logic [tlbfa_pkg::PAGE_W-1:0]     n_ppage [TLB_ENTRIES];
    logic [RW-1:0]                    r_rank  [TLB_ENTRIES];
    logic [RW-1:0]                    n_rank  [TLB_ENTRIES];
    logic [tlbfa_pkg::CNT_W-1:0]      r_hit_cnt, n_hit_cnt;
    logic [tlbfa_pkg::CNT_W-1:0]      r_miss_cnt, n_miss_cnt;

    logic [TLB_ENTRIES-1:0]           match, match_oh, free_oh, victim_oh, tgt_oh;
    logic                             any_match, full;
    logic [RW-1:0]                    tgt_rank;
    logic [tlbfa_pkg::PAGE_W-1:0]     hit_ppage;

    // Tag compare and slot selection; all selects are one-hot so no indexed reads.
    always_comb begin
        for (int j = 0; j < TLB_ENTRIES; j++) begin
            match[j]     = r_valid[j] && (r_vpage[j] == i_req.vpage);
            victim_oh[j] = r_valid[j] && (r_rank[j] == OLDEST);
        end
        match_oh  = match & (~match + 1'b1);
        free_oh   = ~r_valid & (r_valid + 1'b1);
        any_match = |match;
        full      = &r_valid;

        if (i_req.op == tlbfa_pkg::OP_ADD && !any_match) begin
            tgt_oh = full ? victim_oh : free_oh;
        end else begin
            tgt_oh = match_oh;
        end

        tgt_rank  = '0;
        hit_ppage = '0;
        for (int j = 0; j < TLB_ENTRIES; j++) begin
            tgt_rank  = tgt_rank  | (tgt_oh[j]   ? r_rank[j]  : '0);
            hit_ppage = hit_ppage | (match_oh[j] ? r_ppage[j] : '0);
        end
    end

    always_comb begin
        n_valid    = r_valid;
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        for (int j = 0; j < TLB_ENTRIES; j++) begin
            n_vpage[j] = r_vpage[j];
            n_ppage[j] = r_ppage[j];
            n_rank[j]  = r_rank[j];
        end

        if (i_step) begin
            case (i_req.op)
                tlbfa_pkg::OP_LOOKUP: begin
                    if (any_match) begin
                        n_hit_cnt = r_hit_cnt + 1'b1;
                        for (int j = 0; j < TLB_ENTRIES; j++) begin
                            if (tgt_oh[j]) begin
                                n_rank[j] = '0;
                            end else if (r_valid[j] && r_rank[j] < tgt_rank) begin
                                n_rank[j] = r_rank[j] + 1'b1;
                            end
                        end
                    end else begin
                        n_miss_cnt = r_miss_cnt + 1'b1;
                    end
                end
                tlbfa_pkg::OP_ADD: begin
                    for (int j = 0; j < TLB_ENTRIES; j++) begin
                        if (tgt_oh[j]) begin
                            n_valid[j] = 1'b1;
                            n_vpage[j] = i_req.vpage;
                            n_ppage[j] = i_req.ppage;
                            n_rank[j]  = '0;
                        end else if (any_match || full) begin
                            if (r_valid[j] && r_rank[j] < tgt_rank) begin
                                n_rank[j] = r_rank[j] + 1'b1;
                            end
                        end else if (r_valid[j]) begin
                            // New entry in a free slot: every live entry ages.
                            n_rank[j] = r_rank[j] + 1'b1;
                        end
                    end
                end
                tlbfa_pkg::OP_INVAL: begin
                    // An absent page leaves the ranks alone.
                    if (any_match) begin
                        for (int j = 0; j < TLB_ENTRIES; j++) begin
                            if (tgt_oh[j]) begin
                                n_valid[j] = 1'b0;
                            end else if (r_valid[j] && r_rank[j] > tgt_rank) begin
                                n_rank[j] = r_rank[j] - 1'b1;
                            end
                        end
                    end
                end
                tlbfa_pkg::OP_INVAL_ALL: begin
                    n_valid = '0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else begin
            r_valid    <= n_valid;
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < TLB_ENTRIES; j++) begin
            r_vpage[j] <= n_vpage[j];
            r_ppage[j] <= n_ppage[j];
            r_rank[j]  <= n_rank[j];
        end
    end

    always_comb begin
        o_res.hit        = (i_req.op == tlbfa_pkg::OP_LOOKUP) && any_match;
        o_res.tpage      = o_res.hit ? hit_ppage : '0;
        o_res.hit_total  = n_hit_cnt;
        o_res.miss_total = n_miss_cnt;
    end

endmodule

`default_nettype wire

### rtl/tlbfa_out_reg.sv
// Result register with valid/ready hold toward the consumer.
`default_nettype none

module tlbfa_out_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  tlbfa_pkg::t_result  i_res,
    input  wire                 i_out_ready,
    output logic                o_valid,
    output tlbfa_pkg::t_result  o_res
);

    logic               r_valid;
    tlbfa_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

### rtl/tlbfa_checker.sv
// Port-level checker for the TLB top level, with its bind statement.
`default_nettype none

module tlbfa_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire        o_hit,
    input wire [31:0] o_translated_page,
    input wire [31:0] o_hit_total,
    input wire [31:0] o_miss_total
);

    // A waiting result word is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit_total)
            && $stable(o_miss_total) && $stable(o_translated_page) && $stable(o_hit))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_translated_page == 32'd0)
        else $error("translated page nonzero without a hit");

    // Consecutive results: the hit count grows exactly by this word's hit flag.
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) ##1 o_out_valid
            |-> o_hit_total == $past(o_hit_total) + {31'd0, o_hit})
        else $error("hit total out of step with hit flag");

endmodule

bind tlb_fully_assoc_lru_top tlbfa_checker u_tlbfa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_hit             (o_hit),
    .o_translated_page (o_translated_page),
    .o_hit_total       (o_hit_total),
    .o_miss_total      (o_miss_total)
);

`default_nettype wire

### test/tlb_lru_checker.sv
// Checker for the TLB: mirrors the translation buffer, predicts each result word and compares.
`timescale 1ns / 100ps

module tlb_lru_checker
    import tlbfa_pkg::*;
#(
    parameter int unsigned TLB_ENTRIES = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_ready,
    input  wire  [1:0]        i_op,
    input  wire  [PAGE_W-1:0] i_virtual_page,
    input  wire  [PAGE_W-1:0] i_physical_page,
    input  wire               i_out_valid,
    input  wire               i_out_ready,
    input  wire               i_hit,
    input  wire  [PAGE_W-1:0] i_translated_page,
    input  wire  [CNT_W-1:0]  i_hit_total,
    input  wire  [CNT_W-1:0]  i_miss_total,
    output int                o_fail_count,
    output int                o_pending
);

    logic              slot_valid [TLB_ENTRIES];
    logic [PAGE_W-1:0] slot_vpage [TLB_ENTRIES];
    logic [PAGE_W-1:0] slot_ppage [TLB_ENTRIES];
    int unsigned       slot_rank  [TLB_ENTRIES];
    logic [CNT_W-1:0]  hits_seen;
    logic [CNT_W-1:0]  misses_seen;
    t_result           expected_results [$];
    int                fail_total = 0;

    function automatic int find_slot(logic [PAGE_W-1:0] vp);
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (slot_valid[i] && slot_vpage[i] == vp) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Slot k becomes most recent; every valid entry that was more recent than it ages by one.
    function automatic void promote_slot(int k);
        int unsigned old_rank;
        old_rank = slot_rank[k];
        for (int j = 0; j < TLB_ENTRIES; j++) begin
            if (j != k && slot_valid[j] && slot_rank[j] < old_rank) begin
                slot_rank[j]++;
            end
        end
        slot_rank[k] = 0;
    endfunction

    task automatic predict_translation(t_op op, logic [PAGE_W-1:0] vp, logic [PAGE_W-1:0] pp);
        t_result     res;
        int          k;
        int unsigned dropped_rank;
        res = '0;
        k   = find_slot(vp);
        case (op)
            OP_LOOKUP: begin
                if (k >= 0) begin
                    promote_slot(k);
                    res.hit   = 1'b1;
                    res.tpage = slot_ppage[k];
                    hits_seen++;
                end else begin
                    misses_seen++;
                end
            end
            OP_ADD: begin
                if (k >= 0) begin
                    slot_ppage[k] = pp;
                    promote_slot(k);
                end else begin
                    for (int j = 0; j < TLB_ENTRIES; j++) begin
                        if (!slot_valid[j] && k < 0) begin
                            k = j;
                        end
                    end
                    if (k >= 0) begin
                        for (int j = 0; j < TLB_ENTRIES; j++) begin
                            if (slot_valid[j]) begin
                                slot_rank[j]++;
                            end
                        end
                        slot_valid[k] = 1'b1;
                        slot_rank[k]  = 0;
                    end else begin
                        // Buffer full: the least recent entry is replaced.
                        k = 0;
                        for (int j = 1; j < TLB_ENTRIES; j++) begin
                            if (slot_rank[j] > slot_rank[k]) begin
                                k = j;
                            end
                        end
                        promote_slot(k);
                    end
                    slot_vpage[k] = vp;
                    slot_ppage[k] = pp;
                end
            end
            OP_INVAL: begin
                if (k >= 0) begin
                    dropped_rank = slot_rank[k];
                    for (int j = 0; j < TLB_ENTRIES; j++) begin
                        if (j != k && slot_valid[j] && slot_rank[j] > dropped_rank) begin
                            slot_rank[j]--;
                        end
                    end
                    slot_valid[k] = 1'b0;
                end
            end
            default: begin
                for (int j = 0; j < TLB_ENTRIES; j++) begin
                    slot_valid[j] = 1'b0;
                end
            end
        endcase
        res.hit_total  = hits_seen;
        res.miss_total = misses_seen;
        expected_results.push_back(res);
    endtask

    task automatic compare_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            if (fail_total < 10) begin
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
            end
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
            end
            hits_seen   = '0;
            misses_seen = '0;
            expected_results.delete();
        end else begin
            // The output side is handled first: a word accepted at this edge
            // cannot have its result on the output at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    if (fail_total < 10) begin
                        $display("%0t: result word with nothing expected", $realtime);
                    end
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("hit", {31'b0, i_hit}, {31'b0, want.hit});
                    compare_field("translated_page", i_translated_page, want.tpage);
                    compare_field("hit_total", i_hit_total, want.hit_total);
                    compare_field("miss_total", i_miss_total, want.miss_total);
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_translation(t_op'(i_op), i_virtual_page, i_physical_page);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

### test/tb_tlb_fully_assoc_lru_top.sv
// Testbench top for the TLB: drives the request words and gives the verdict.
`timescale 1ns / 100ps

module tb_tlb_fully_assoc_lru_top;
    import tlbfa_pkg::*;

    localparam int unsigned TLB_ENTRIES  = 16;
    localparam int unsigned VPAGE_POOL   = 24;
    localparam int          RANDOM_WORDS = 1000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    t_op               op_drv      = OP_LOOKUP;
    logic [PAGE_W-1:0] vpage_drv   = '0;
    logic [PAGE_W-1:0] ppage_drv   = '0;
    logic              out_ready   = 1'b0;
    logic              quiet_phase = 1'b0;

    wire               in_ready;
    wire               out_valid;
    wire               hit;
    wire  [PAGE_W-1:0] translated_page;
    wire  [CNT_W-1:0]  hit_total;
    wire  [CNT_W-1:0]  miss_total;
    int                fail_count;
    int                pending_count;

    always #5 clk = ~clk;

    tlb_fully_assoc_lru_top #(
        .TLB_ENTRIES(TLB_ENTRIES)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_op             (op_drv),
        .i_virtual_page   (vpage_drv),
        .i_physical_page  (ppage_drv),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_hit            (hit),
        .o_translated_page(translated_page),
        .o_hit_total      (hit_total),
        .o_miss_total     (miss_total)
    );

    tlb_lru_checker #(
        .TLB_ENTRIES(TLB_ENTRIES)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_op             (op_drv),
        .i_virtual_page   (vpage_drv),
        .i_physical_page  (ppage_drv),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_hit            (hit),
        .i_translated_page(translated_page),
        .i_hit_total      (hit_total),
        .i_miss_total     (miss_total),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count)
    );

    always @(posedge clk) begin
        out_ready <= rst_n && (quiet_phase || $urandom_range(99) >= 16);
    end

    task automatic send_word(t_op op, logic [PAGE_W-1:0] vp, logic [PAGE_W-1:0] pp);
        while (!quiet_phase && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op_drv    <= op;
        vpage_drv <= vp;
        ppage_drv <= pp;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        logic [PAGE_W-1:0] vpage_pool [VPAGE_POOL];
        logic [PAGE_W-1:0] vp;
        int unsigned       pick;
        t_op               op;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme pages, hits, an in-place update and invalidation.
        send_word(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(OP_ADD, 32'h0000_0000, 32'h1234_5678);
        send_word(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(OP_INVAL, 32'h0000_0005, 32'h0000_0000);
        send_word(OP_INVAL, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

        // Fill the free slots, refresh the oldest entry, then force an eviction.
        for (int i = 0; i < TLB_ENTRIES - 1; i++) begin
            send_word(OP_ADD, 32'h0000_1000 + i, ~(32'h0000_1000 + i));
        end
        send_word(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_ADD, 32'h0000_2000, 32'hA5A5_5A5A);
        send_word(OP_LOOKUP, 32'h0000_1000, 32'h0000_0000);
        send_word(OP_INVAL_ALL, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_LOOKUP, 32'h0000_2000, 32'h0000_0000);
        wait_for_results();

        // A pool larger than the buffer keeps hits frequent and evictions happening.
        for (int i = 0; i < VPAGE_POOL; i++) begin
            vpage_pool[i] = $urandom;
        end
        vpage_pool[0] = 32'h0000_0000;
        vpage_pool[1] = 32'hFFFF_FFFF;

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 200) begin
                quiet_phase <= 1'b1;
            end
            if (n == 400) begin
                quiet_phase <= 1'b0;
            end
            if (n == 600) begin
                wait_for_results();
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                op = OP_LOOKUP;
            end else if (pick < 85) begin
                op = OP_ADD;
            end else if (pick < 98) begin
                op = OP_INVAL;
            end else begin
                op = OP_INVAL_ALL;
            end
            if ($urandom_range(9) == 0) begin
                vp = $urandom;
            end else begin
                vp = vpage_pool[$urandom_range(VPAGE_POOL - 1)];
            end
            send_word(op, vp, $urandom);
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
